FILE: src/assert_macros.svh
// assertion macros used by the interval set rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ISMU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ISMU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ismu_pkg.sv
// types, codes and helpers for the interval set insert/merge unit
package ismu_pkg;

  localparam int MODE_W   = 2;
  localparam int RANGE_W  = 16;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  // compare width: one bit above a range value so that end + 1 never wraps
  localparam int CMP_W    = RANGE_W + 1;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [RANGE_W-1:0] range_begin;
    logic [RANGE_W-1:0] range_end;
    logic [INDEX_W-1:0] index;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  range_count;
    logic [RANGE_W-1:0]  entry_begin;
    logic [RANGE_W-1:0]  entry_end;
  } rsp_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MERGE,
    ST_DONE
  } state_t;

  // what every cell does with its entry this cycle
  typedef enum logic [1:0] {
    PH_HOLD,
    PH_ABSORB,
    PH_INSERT,
    PH_MERGE
  } phase_t;

  // prefix flags rippling from cell 0 toward the last cell
  typedef struct packed {
    logic hit_seen;
    logic ins_seen;
    logic mrg_seen;
  } chain_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              order_err;
    logic              read_ok;
    logic              any_hit;
    logic              merge_found;
  } ctrl_flags_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    phase_t phase;
    logic   exec;
    logic   rsp_load;
  } ctrl_out_t;

  // two closed ranges overlap or leave a gap of at most one
  function automatic logic touches(input logic [CMP_W-1:0] kb, input logic [CMP_W-1:0] ke,
                                   input logic [CMP_W-1:0] b, input logic [CMP_W-1:0] e);
    logic one_way;
    logic other_way;
    one_way   = (b <= ke + CMP_W'(1)) && (kb <= e);
    other_way = (kb <= e + CMP_W'(1)) && (b <= ke);
    return one_way || other_way;
  endfunction

endpackage

FILE: src/ismu_cell.sv
// one table entry with its local compares and neighbor handoff
module ismu_cell #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 5,
  parameter int VAL_W      = 16
) (
  input  logic                 clk,
  input  ismu_pkg::phase_t     phase,
  input  logic [CNT_W-1:0]     count,
  input  logic [CNT_W-1:0]     scan_start,
  input  logic [VAL_W-1:0]     new_begin,
  input  logic [VAL_W-1:0]     new_end,
  input  logic [VAL_W-1:0]     left_begin,
  input  logic [VAL_W-1:0]     left_end,
  input  logic [VAL_W-1:0]     right_begin,
  input  logic [VAL_W-1:0]     right_end,
  input  ismu_pkg::chain_t     chain_in,
  output ismu_pkg::chain_t     chain_out,
  output logic                 first_merge,
  output logic [VAL_W-1:0]     cur_begin,
  output logic [VAL_W-1:0]     cur_end
);
  import ismu_pkg::*;

  logic             in_use;
  logic             pair_ok;
  logic             after_start;
  logic             hit_here;
  logic             first_hit;
  logic             ins_here;
  logic             merge_cand;
  logic [VAL_W-1:0] begin_next;
  logic [VAL_W-1:0] end_next;

  // position of this cell against the fill count and the scan start
  assign in_use      = CNT_W'(CELL_INDEX) < count;
  assign pair_ok     = CNT_W'(CELL_INDEX + 1) < count;
  assign after_start = CNT_W'(CELL_INDEX) >= scan_start;

  // local tests against the new range and against the right neighbor
  assign hit_here   = in_use && touches(CMP_W'(cur_begin), CMP_W'(cur_end),
                                        CMP_W'(new_begin), CMP_W'(new_end));
  assign first_hit  = hit_here && !chain_in.hit_seen;
  assign ins_here   = !chain_in.ins_seen && (!in_use || (new_begin < cur_begin));
  assign merge_cand = after_start && pair_ok &&
                      touches(CMP_W'(cur_begin), CMP_W'(cur_end),
                              CMP_W'(right_begin), CMP_W'(right_end));
  assign first_merge = merge_cand && !chain_in.mrg_seen;

  always_comb begin
    chain_out.hit_seen = chain_in.hit_seen || hit_here;
    chain_out.ins_seen = chain_in.ins_seen || ins_here;
    chain_out.mrg_seen = chain_in.mrg_seen || merge_cand;
  end

  // next entry value
  always_comb begin
    begin_next = cur_begin;
    end_next   = cur_end;
    case (phase)
      PH_ABSORB: begin
        if (first_hit) begin
          begin_next = (new_begin < cur_begin) ? new_begin : cur_begin;
          end_next   = (new_end > cur_end) ? new_end : cur_end;
        end
      end
      PH_INSERT: begin
        if (ins_here) begin
          begin_next = new_begin;
          end_next   = new_end;
        end else if (chain_in.ins_seen) begin
          begin_next = left_begin;
          end_next   = left_end;
        end
      end
      PH_MERGE: begin
        if (first_merge) begin
          begin_next = (right_begin < cur_begin) ? right_begin : cur_begin;
          end_next   = (right_end > cur_end) ? right_end : cur_end;
        end else if (chain_in.mrg_seen) begin
          begin_next = right_begin;
          end_next   = right_end;
        end
      end
      default: begin
        begin_next = cur_begin;
        end_next   = cur_end;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_begin <= begin_next;
    cur_end   <= end_next;
  end

endmodule

FILE: src/ismu_ctrl.sv
// sequencer: handshake, fill count, scan start and status
module ismu_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            rsp_ready,
  input  ismu_pkg::ctrl_flags_t           flags,
  input  logic [CNT_W-1:0]                merge_pos,
  output logic                            req_ready,
  output logic                            rsp_valid,
  output ismu_pkg::ctrl_out_t             ctl,
  output logic [ismu_pkg::STATUS_W-1:0]   status,
  output logic [CNT_W-1:0]                count,
  output logic [CNT_W-1:0]                scan_start
);
  import ismu_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    scan_start_next;
  logic [STATUS_W-1:0] status_next;
  logic                rsp_valid_next;
  logic                is_insert;
  logic                room;

  assign is_insert = (flags.mode == MODE_INSERT) && !flags.order_err;
  assign room      = count < CNT_W'(CAPACITY);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_insert && (flags.any_hit || room)) begin
          state_next = ST_MERGE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_MERGE: begin
        if (!flags.merge_found) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to the handshake and the cells
  always_comb begin
    ctl.phase    = PH_HOLD;
    ctl.exec     = 1'b0;
    ctl.rsp_load = 1'b0;
    req_ready    = 1'b0;
    case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_EXEC: begin
        ctl.exec = 1'b1;
        if (is_insert) begin
          if (flags.any_hit) begin
            ctl.phase = PH_ABSORB;
          end else if (room) begin
            ctl.phase = PH_INSERT;
          end
        end
      end
      ST_MERGE: begin
        if (flags.merge_found) begin
          ctl.phase = PH_MERGE;
        end
      end
      ST_DONE: ctl.rsp_load = !rsp_valid || rsp_ready;
      default: req_ready = 1'b0;
    endcase
  end

  // count, scan start and status
  always_comb begin
    count_next      = count;
    scan_start_next = scan_start;
    status_next     = status;
    if (ctl.exec) begin
      scan_start_next = '0;
      status_next     = STATUS_OK;
      case (flags.mode)
        MODE_INSERT: begin
          if (flags.order_err) begin
            status_next = STATUS_ORDER;
          end else if (!flags.any_hit && !room) begin
            status_next = STATUS_FULL;
          end
        end
        MODE_READ: begin
          if (!flags.read_ok) begin
            status_next = STATUS_INDEX;
          end
        end
        MODE_CLEAR: count_next = '0;
        default:    status_next = STATUS_OK;
      endcase
    end
    if (ctl.phase == PH_INSERT) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.phase == PH_MERGE) begin
      count_next      = count - CNT_W'(1);
      scan_start_next = merge_pos;
    end
  end

  // response valid holds until taken
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (ctl.rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      scan_start <= '0;
      status     <= STATUS_OK;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      scan_start <= scan_start_next;
      status     <= status_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

endmodule

FILE: src/interval_set_insert_merge_unit.sv
// Insert: EXEC, then MERGE until no touching pair remains (m merge steps, m < CAPACITY), then
// DONE. Begin after end, table full, read, clear and unused modes: EXEC, then DONE. DONE loads
// the result once the output register is free. One transaction in flight; the next can be
// accepted in the cycle after the result loads, while the result may still wait in the output register.
// In each merge step the row of cells finds the first touching pair and shifts.
// Reset empties the table (count zero); entry contents stay undefined until written.
module interval_set_insert_merge_unit #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  ismu_pkg::req_item_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output ismu_pkg::rsp_item_t  rsp
);
  import ismu_pkg::*;
  `include "assert_macros.svh"

  localparam int VAL_W = (VALUE_WIDTH < RANGE_W) ? VALUE_WIDTH : RANGE_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_CMP_W = CNT_W + INDEX_W;

  req_item_t           req_q;
  rsp_item_t           rsp_q;
  ctrl_flags_t         flags;
  ctrl_out_t           ctl;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    scan_start;
  logic [CNT_W-1:0]    merge_pos;
  logic [VAL_W-1:0]    new_begin;
  logic [VAL_W-1:0]    new_end;
  logic [VAL_W-1:0]    rd_begin;
  logic [VAL_W-1:0]    rd_end;
  logic [VAL_W-1:0]    entry_begin_q;
  logic [VAL_W-1:0]    entry_end_q;
  logic                read_ok;
  logic                req_fire;
  logic                merge_step;
  logic                rsp_full;

  logic [VAL_W-1:0]    cell_begin [CAPACITY];
  logic [VAL_W-1:0]    cell_end   [CAPACITY];
  logic                first_merge [CAPACITY];
  chain_t              chain [CAPACITY + 1];

  assign req_fire = req_valid && req_ready;

  // latch the request transaction
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q <= req;
    end
  end

  assign new_begin = req_q.range_begin[VAL_W-1:0];
  assign new_end   = req_q.range_end[VAL_W-1:0];
  assign read_ok   = IDX_CMP_W'(req_q.index) < IDX_CMP_W'(count);

  // row of cells
  assign chain[0] = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VAL_W-1:0] left_begin;
    logic [VAL_W-1:0] left_end;
    logic [VAL_W-1:0] right_begin;
    logic [VAL_W-1:0] right_end;

    if (k == 0) begin : g_first
      assign left_begin = '0;
      assign left_end   = '0;
    end else begin : g_inner_left
      assign left_begin = cell_begin[k-1];
      assign left_end   = cell_end[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_begin = '0;
      assign right_end   = '0;
    end else begin : g_inner_right
      assign right_begin = cell_begin[k+1];
      assign right_end   = cell_end[k+1];
    end

    ismu_cell #(
      .CELL_INDEX (k),
      .CNT_W      (CNT_W),
      .VAL_W      (VAL_W)
    ) u_cell (
      .clk         (clk),
      .phase       (ctl.phase),
      .count       (count),
      .scan_start  (scan_start),
      .new_begin   (new_begin),
      .new_end     (new_end),
      .left_begin  (left_begin),
      .left_end    (left_end),
      .right_begin (right_begin),
      .right_end   (right_end),
      .chain_in    (chain[k]),
      .chain_out   (chain[k+1]),
      .first_merge (first_merge[k]),
      .cur_begin   (cell_begin[k]),
      .cur_end     (cell_end[k])
    );
  end

  // read select and merge position, one-hot over the cells
  always_comb begin
    rd_begin  = '0;
    rd_end    = '0;
    merge_pos = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (IDX_CMP_W'(req_q.index) == IDX_CMP_W'(k)) begin
        rd_begin = rd_begin | cell_begin[k];
        rd_end   = rd_end | cell_end[k];
      end
      if (first_merge[k]) begin
        merge_pos = merge_pos | CNT_W'(k);
      end
    end
  end

  always_comb begin
    flags.mode        = req_q.mode;
    flags.order_err   = new_begin > new_end;
    flags.read_ok     = read_ok;
    flags.any_hit     = chain[CAPACITY].hit_seen;
    flags.merge_found = chain[CAPACITY].mrg_seen;
  end

  ismu_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .rsp_ready  (rsp_ready),
    .flags      (flags),
    .merge_pos  (merge_pos),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .ctl        (ctl),
    .status     (status),
    .count      (count),
    .scan_start (scan_start)
  );

  // read data captured while the command executes
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      if ((req_q.mode == MODE_READ) && read_ok) begin
        entry_begin_q <= rd_begin;
        entry_end_q   <= rd_end;
      end else begin
        entry_begin_q <= '0;
        entry_end_q   <= '0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (ctl.rsp_load) begin
      rsp_q.status      <= status;
      rsp_q.range_count <= COUNT_W'(count);
      rsp_q.entry_begin <= RANGE_W'(entry_begin_q);
      rsp_q.entry_end   <= RANGE_W'(entry_end_q);
    end
  end

  assign rsp = rsp_q;

  // checks
  assign merge_step = ctl.phase == PH_MERGE;
  assign rsp_full   = rsp_valid && (rsp.status == STATUS_FULL);

  `ISMU_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `ISMU_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready, "second transaction taken while busy")
  `ISMU_ASSERT_NEXT(a_merge_shrinks, merge_step, count == $past(count) - CNT_W'(1), "count not dropped")
  `ISMU_ASSERT_NOW(a_full_count, rsp_full, rsp.range_count == COUNT_W'(CAPACITY), "full with free room")

endmodule

FILE: sim/interval_set_insert_merge_unit_tb.sv
// testbench for the interval set insert/merge unit: directed and random transactions, predicted
module interval_set_insert_merge_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ismu_pkg::*;

  localparam int CAPACITY = 16;
  localparam int unsigned VALUE_MAX = 65535;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  // shadow copy of the range table
  logic [RANGE_W-1:0] shadow_begin [CAPACITY];
  logic [RANGE_W-1:0] shadow_end [CAPACITY];
  int unsigned        shadow_count = 0;

  rsp_item_t   answers_due [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  interval_set_insert_merge_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (RANGE_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // widen entry k with [b, e] when they overlap or leave a gap of at most one
  function automatic bit widen_entry(int unsigned k, int unsigned b, int unsigned e);
    int unsigned kb;
    int unsigned ke;
    kb = 32'(shadow_begin[k]);
    ke = 32'(shadow_end[k]);
    if (!(((b <= ke + 1) && (kb <= e)) || ((kb <= e + 1) && (b <= ke)))) return 1'b0;
    if (b < kb) shadow_begin[k] = RANGE_W'(b);
    if (e > ke) shadow_end[k] = RANGE_W'(e);
    return 1'b1;
  endfunction

  // one pass from the front folding each entry into the last kept one
  function automatic void fold_neighbours();
    int unsigned keep;
    keep = 0;
    if (shadow_count == 0) return;
    for (int unsigned j = 1; j < shadow_count; j++) begin
      if (!widen_entry(keep, 32'(shadow_begin[j]), 32'(shadow_end[j]))) begin
        keep++;
        shadow_begin[keep] = shadow_begin[j];
        shadow_end[keep]   = shadow_end[j];
      end
    end
    shadow_count = keep + 1;
  endfunction

  // insert one range, returns the status code
  function automatic logic [STATUS_W-1:0] insert_range(int unsigned b, int unsigned e);
    int unsigned pos;
    if (b > e) return STATUS_ORDER;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (widen_entry(i, b, e)) begin
        fold_neighbours();
        return STATUS_OK;
      end
    end
    if (shadow_count >= CAPACITY) return STATUS_FULL;
    pos = 0;
    while (pos < shadow_count && b >= 32'(shadow_begin[pos])) pos++;
    for (int unsigned j = shadow_count; j > pos; j--) begin
      shadow_begin[j] = shadow_begin[j-1];
      shadow_end[j]   = shadow_end[j-1];
    end
    shadow_begin[pos] = RANGE_W'(b);
    shadow_end[pos]   = RANGE_W'(e);
    shadow_count++;
    fold_neighbours();
    return STATUS_OK;
  endfunction

  // apply one request to the shadow table and form its answer
  function automatic rsp_item_t answer_of(req_item_t item);
    rsp_item_t ans;
    ans = '0;
    case (item.mode)
      MODE_INSERT: begin
        ans.status = insert_range(32'(item.range_begin), 32'(item.range_end));
      end
      MODE_READ: begin
        if (32'(item.index) < shadow_count) begin
          ans.entry_begin = shadow_begin[item.index];
          ans.entry_end   = shadow_end[item.index];
        end else begin
          ans.status = STATUS_INDEX;
        end
      end
      MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    ans.range_count = COUNT_W'(shadow_count);
    return ans;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // check result transactions against the oldest answer, then log accepted requests
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(rsp.status), 0);
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.range_count !== want.range_count)
            report_mismatch("range_count", 32'(rsp.range_count), 32'(want.range_count));
          if (rsp.entry_begin !== want.entry_begin)
            report_mismatch("entry_begin", 32'(rsp.entry_begin), 32'(want.entry_begin));
          if (rsp.entry_end !== want.entry_end)
            report_mismatch("entry_end", 32'(rsp.entry_end), 32'(want.entry_end));
        end
      end
      if (req_valid && req_ready) answers_due.push_back(answer_of(req));
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: bursts of ready split by random stalls
  initial begin : result_sink
    int unsigned stall;
    int unsigned burst;
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        rsp_ready <= 1'b0;
      end
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        @(negedge clk);
        rsp_ready <= 1'b1;
      end
    end
  end

  // send one request transaction after a random gap, return once accepted
  task automatic send_request(req_item_t item);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  function automatic req_item_t pack_request(logic [MODE_W-1:0] mode, int unsigned b,
                                             int unsigned e, int unsigned idx);
    req_item_t item;
    item.mode        = mode;
    item.range_begin = RANGE_W'(b);
    item.range_end   = RANGE_W'(e);
    item.index       = INDEX_W'(idx);
    return item;
  endfunction

  // random request: mostly well-formed inserts near the given span, plus noise
  function automatic req_item_t random_request(int unsigned span, int unsigned len_max);
    req_item_t   item;
    int unsigned r;
    int unsigned b;
    int unsigned e;
    int unsigned len;
    item = pack_request(MODE_INSERT, $urandom_range(0, VALUE_MAX),
                        $urandom_range(0, VALUE_MAX), $urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      b   = $urandom_range(0, span);
      len = $urandom_range(0, len_max);
      e   = (b + len > VALUE_MAX) ? VALUE_MAX : b + len;
      item.range_begin = RANGE_W'(b);
      item.range_end   = RANGE_W'(e);
    end else if (r < 65) begin
      // begin after end
      b = $urandom_range(1, VALUE_MAX);
      e = $urandom_range(0, b - 1);
      item.range_begin = RANGE_W'(b);
      item.range_end   = RANGE_W'(e);
    end else if (r < 68) begin
      // ranges pinned to either edge of the value space
      if ($urandom_range(0, 1)) begin
        item.range_begin = '0;
        item.range_end   = RANGE_W'($urandom_range(0, len_max));
      end else begin
        item.range_end   = '1;
        item.range_begin = RANGE_W'(VALUE_MAX - $urandom_range(0, len_max));
      end
    end else if (r < 91) begin
      item.mode = MODE_READ;
    end else if (r < 93) begin
      item.mode = MODE_CLEAR;
    end else begin
      item.mode = MODE_UNUSED;
    end
    return item;
  endfunction

  // edge values, merge by a bridging range, order error, unused mode, reads
  task automatic test_edge_values();
    send_request(pack_request(MODE_READ, 0, 0, 15));
    send_request(pack_request(MODE_INSERT, 0, 0, 0));
    send_request(pack_request(MODE_INSERT, VALUE_MAX, VALUE_MAX, 0));
    send_request(pack_request(MODE_INSERT, 2, 3, 0));
    send_request(pack_request(MODE_INSERT, 1, 1, 0));
    send_request(pack_request(MODE_INSERT, 40000, 39999, 0));
    send_request(pack_request(MODE_UNUSED, VALUE_MAX, VALUE_MAX, 15));
    send_request(pack_request(MODE_READ, 0, 0, 0));
    send_request(pack_request(MODE_READ, VALUE_MAX, VALUE_MAX, 2));
  endtask

  // fill to capacity from the front, then full, touching and all-covering inserts
  task automatic test_full_table();
    send_request(pack_request(MODE_CLEAR, 0, 0, 0));
    for (int k = CAPACITY - 1; k >= 0; k--)
      send_request(pack_request(MODE_INSERT, k * 1000, k * 1000 + 10, 0));
    send_request(pack_request(MODE_INSERT, 500, 600, 0));
    send_request(pack_request(MODE_INSERT, 11, 11, 0));
    send_request(pack_request(MODE_READ, 0, 0, 15));
    send_request(pack_request(MODE_INSERT, 0, VALUE_MAX, 0));
    send_request(pack_request(MODE_READ, 0, 0, 0));
  endtask

  // small value space: heavy widening and folding
  task automatic test_dense_merging(int unsigned n);
    repeat (n) send_request(random_request(80, 4));
  endtask

  // whole value space: table fills and reports full
  task automatic test_sparse_filling(int unsigned n);
    repeat (n) send_request(random_request(VALUE_MAX, 300));
  endtask

  // both shapes mixed, the first stretch with no idling on either side
  task automatic test_mixed_unpaced(int unsigned n);
    calm = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 3) calm = 1'b0;
      if ($urandom_range(0, 1)) send_request(random_request(80, 4));
      else send_request(random_request(VALUE_MAX, 300));
    end
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_begin[i] = '0;
      shadow_end[i]   = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_values();
    test_full_table();
    test_dense_merging(250);
    test_sparse_filling(250);
    test_mixed_unpaced(250);

    @(negedge clk);
    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
